// ===== rtl/hhr_pkg.sv =====
// Package for the HSV/HSL to RGB converter: codes, constants, shared structs
// and the input clamp functions.
// No dependencies; every module of the converter imports it.
package hhr_pkg;

   // Default fraction width of the fixed-point color math
   localparam int FRAC_BITS_DEFAULT = 16;

   // Range limits of the color fields
   localparam logic [7:0] CHAN_MAX   = 8'd255;
   localparam logic [6:0] PCT_MAX    = 7'd100;
   localparam logic [8:0] HUE_MAX    = 9'd359;
   localparam logic [5:0] SECTOR_DEG = 6'd60;

   // Color model selector
   typedef enum logic [1:0] {
      FUNC_RGB  = 2'd0,
      FUNC_HSV  = 2'd1,
      FUNC_HSL  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   // Request payload as captured from the input channel
   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] first_value;
      logic [10:0] second_value;
      logic [10:0] third_value;
      logic [10:0] alpha_in;
   } req_data_type;

   // Control that travels with every request down the pipeline
   typedef struct packed {
      logic       valid;
      func_type   func;
      logic [2:0] sector;
      logic [5:0] weight;
      logic [7:0] red_pass;
      logic [7:0] green_pass;
      logic [7:0] blue_pass;
      logic [7:0] alpha;
   } ctl_type;

   // Result register contents
   typedef struct packed {
      logic       valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_out;
   } rsp_data_type;

   // Clamp a signed field to 0..255
   function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
      logic [7:0] r;
      if (v[10]) begin
         r = '0;
      end else if (v > $signed({3'b000, CHAN_MAX})) begin
         r = CHAN_MAX;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // Clamp a signed field to 0..100 percent
   function automatic logic [6:0] clamp_pct(input logic signed [10:0] v);
      logic [6:0] r;
      if (v[10]) begin
         r = '0;
      end else if (v > $signed({4'b0000, PCT_MAX})) begin
         r = PCT_MAX;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   // Clamp a signed field to 0..359 degrees
   function automatic logic [8:0] clamp_hue(input logic signed [10:0] v);
      logic [8:0] r;
      if (v[10]) begin
         r = '0;
      end else if (v > $signed({2'b00, HUE_MAX})) begin
         r = HUE_MAX;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/hhr_req_if.sv =====
// Request channel of the HSV/HSL to RGB converter: valid/ready plus payload.
// Depends on nothing; field widths are fixed by the channel format.
interface hhr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [10:0] first_value;
   logic signed [10:0] second_value;
   logic signed [10:0] third_value;
   logic signed [10:0] alpha_in;

   modport source (
      output valid, func, first_value, second_value, third_value, alpha_in,
      input  ready
   );
   modport sink (
      input  valid, func, first_value, second_value, third_value, alpha_in,
      output ready
   );
endinterface

// ===== rtl/hhr_rsp_if.sv =====
// Response channel of the HSV/HSL to RGB converter: valid/ready plus RGBA.
// Depends on nothing; field widths are fixed by the channel format.
interface hhr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha_out;

   modport source (
      output valid, red, green, blue, alpha_out,
      input  ready
   );
   modport sink (
      input  valid, red, green, blue, alpha_out,
      output ready
   );
endinterface

// ===== rtl/hhr_front.sv =====
// First pipeline stage: clamp the request, convert percentages to fixed point,
// find the hue sector and form the chroma multiplier operand. Uses hhr_pkg.
module hhr_front
   import hhr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  req_data_type         req_data,
   output ctl_type              ctl_out,
   output logic [FRAC_BITS:0]   sat_q,
   output logic [FRAC_BITS:0]   lum_q,
   output logic [FRAC_BITS:0]   mul_q
);

   // 1.0 in fixed point, one bit of headroom above
   localparam logic [FRAC_BITS+1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

   // Percent to fixed point: floor(p * 2^FRAC_BITS / 100), built at elaboration
   logic [FRAC_BITS:0] pct_tbl [0:PCT_MAX];

   for (genvar i = 0; i <= PCT_MAX; i++) begin : g_pct
      localparam longint unsigned PCT_VAL =
         (longint'(i) << FRAC_BITS) / longint'(PCT_MAX);
      assign pct_tbl[i] = PCT_VAL[FRAC_BITS:0];
   end

   logic [8:0]           hue;
   logic [6:0]           sat_pct;
   logic [6:0]           lum_pct;
   logic [FRAC_BITS:0]   sat_val;
   logic [FRAC_BITS:0]   lum_val;
   logic [2:0]           sector;
   logic [8:0]           sector_base;
   logic [8:0]           offset;
   logic [5:0]           weight;
   logic [FRAC_BITS+1:0] twice_lum;
   logic [FRAC_BITS+1:0] deviation;
   logic [FRAC_BITS+1:0] hsl_span;
   ctl_type              ctl_in;
   ctl_type              ctl_ff;
   logic [FRAC_BITS:0]   sat_in;
   logic [FRAC_BITS:0]   sat_ff;
   logic [FRAC_BITS:0]   lum_in;
   logic [FRAC_BITS:0]   lum_ff;
   logic [FRAC_BITS:0]   mul_in;
   logic [FRAC_BITS:0]   mul_ff;

   // Clamp and look up the fixed-point saturation and value/lightness
   always_comb begin
      hue     = clamp_hue(req_data.first_value);
      sat_pct = clamp_pct(req_data.second_value);
      lum_pct = clamp_pct(req_data.third_value);
      sat_val = pct_tbl[sat_pct];
      lum_val = pct_tbl[lum_pct];
   end

   // Pick the 60-degree sector and the hue weight within it
   always_comb begin
      sector = 3'd5;
      for (int k = 4; k >= 0; k--) begin
         if (hue < 9'((k + 1) * int'(SECTOR_DEG))) begin
            sector = 3'(k);
         end
      end
      sector_base = {6'd0, sector} * {3'd0, SECTOR_DEG};
      offset      = hue - sector_base;
      // rising edge of the ramp in even sectors, falling edge in odd ones
      weight      = sector[0] ? (SECTOR_DEG - offset[5:0]) : offset[5:0];
   end

   // Form the chroma operand: value for HSV, 1 - |2L - 1| for HSL
   always_comb begin
      twice_lum = {lum_val, 1'b0};
      if (twice_lum >= ONE_Q) begin
         deviation = twice_lum - ONE_Q;
      end else begin
         deviation = ONE_Q - twice_lum;
      end
      hsl_span = ONE_Q - deviation;
      if (func_type'(req_data.func) == FUNC_HSL) begin
         mul_in = hsl_span[FRAC_BITS:0];
      end else begin
         mul_in = lum_val;
      end
      sat_in = sat_val;
      lum_in = lum_val;
   end

   // Collect control for the downstream stages
   always_comb begin
      ctl_in.valid      = in_valid;
      ctl_in.func       = func_type'(req_data.func);
      ctl_in.sector     = sector;
      ctl_in.weight     = weight;
      ctl_in.red_pass   = clamp_byte(req_data.first_value);
      ctl_in.green_pass = clamp_byte(req_data.second_value);
      ctl_in.blue_pass  = clamp_byte(req_data.third_value);
      ctl_in.alpha      = clamp_byte(req_data.alpha_in);
   end

   // Stage register; hold while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         sat_ff <= sat_in;
         lum_ff <= lum_in;
         mul_ff <= mul_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign sat_q   = sat_ff;
   assign lum_q   = lum_ff;
   assign mul_q   = mul_ff;

endmodule

// ===== rtl/hhr_chroma.sv =====
// Chroma stages: multiply out chroma, form the offset, scale chroma by the
// hue weight and divide by 60 with a reciprocal multiply. Uses hhr_pkg.
module hhr_chroma
   import hhr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ctl_type            ctl_in,
   input  logic [FRAC_BITS:0] sat_q,
   input  logic [FRAC_BITS:0] lum_q,
   input  logic [FRAC_BITS:0] mul_q,
   output ctl_type            ctl_out,
   output logic [FRAC_BITS:0] chroma,
   output logic [FRAC_BITS:0] ramp,
   output logic [FRAC_BITS:0] offset_m
);

   // Division by 60 is a drop of the two low bits and then a division by 15.
   // With a reciprocal of VAL_W + 4 fraction bits the truncated quotient is
   // exact over the whole operand range.
   localparam int PRE_SHIFT   = 2;
   localparam int DIV_PART    = int'(SECTOR_DEG) >> PRE_SHIFT;
   localparam int PROD_W      = FRAC_BITS + 7;
   localparam int VAL_W       = PROD_W - PRE_SHIFT;
   localparam int RECIP_SHIFT = VAL_W + 4;
   localparam int RECIP_W     = RECIP_SHIFT - 3;
   localparam longint unsigned RECIP_L =
      ((longint'(1) << RECIP_SHIFT) + longint'(DIV_PART - 1)) / longint'(DIV_PART);
   localparam logic [RECIP_W-1:0] RECIP_Q = RECIP_L[RECIP_W-1:0];

   logic [2*FRAC_BITS+1:0]     chroma_prod;
   logic [FRAC_BITS:0]         chroma2_in;
   logic [FRAC_BITS:0]         chroma2_ff;
   logic [FRAC_BITS:0]         lum2_ff;
   ctl_type                    ctl2_ff;

   logic [PROD_W-1:0]          ramp3_in;
   logic [PROD_W-1:0]          ramp3_ff;
   logic [FRAC_BITS:0]         m3_in;
   logic [FRAC_BITS:0]         m3_ff;
   logic [FRAC_BITS:0]         chroma3_ff;
   ctl_type                    ctl3_ff;

   logic [VAL_W-1:0]           quot_val;
   logic [VAL_W+RECIP_W-1:0]   quot_prod;
   logic [FRAC_BITS:0]         ramp4_in;
   logic [FRAC_BITS:0]         ramp4_ff;
   logic [FRAC_BITS:0]         m4_ff;
   logic [FRAC_BITS:0]         chroma4_ff;
   ctl_type                    ctl4_ff;

   // Chroma: operand times saturation, back to FRAC_BITS fraction bits
   always_comb begin
      chroma_prod = {{(FRAC_BITS+1){1'b0}}, mul_q} * {{(FRAC_BITS+1){1'b0}}, sat_q};
      chroma2_in  = chroma_prod[2*FRAC_BITS:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl2_ff    <= ctl_in;
         chroma2_ff <= chroma2_in;
         lum2_ff    <= lum_q;
      end
   end

   // Weight the chroma by the hue ramp and form the offset m
   always_comb begin
      ramp3_in = {6'd0, chroma2_ff} * {{(FRAC_BITS+1){1'b0}}, ctl2_ff.weight};
      if (ctl2_ff.func == FUNC_HSV) begin
         m3_in = lum2_ff - chroma2_ff;
      end else begin
         m3_in = lum2_ff - {1'b0, chroma2_ff[FRAC_BITS:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl3_ff    <= ctl2_ff;
         ramp3_ff   <= ramp3_in;
         m3_ff      <= m3_in;
         chroma3_ff <= chroma2_ff;
      end
   end

   // Divide the weighted chroma by 60
   always_comb begin
      quot_val  = ramp3_ff[PROD_W-1:PRE_SHIFT];
      quot_prod = {{RECIP_W{1'b0}}, quot_val} * {{VAL_W{1'b0}}, RECIP_Q};
      ramp4_in  = quot_prod[RECIP_SHIFT +: FRAC_BITS+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl4_ff    <= ctl3_ff;
         ramp4_ff   <= ramp4_in;
         m4_ff      <= m3_ff;
         chroma4_ff <= chroma3_ff;
      end
   end

   assign ctl_out  = ctl4_ff;
   assign chroma   = chroma4_ff;
   assign ramp     = ramp4_ff;
   assign offset_m = m4_ff;

endmodule

// ===== rtl/hhr_mix.sv =====
// Output stages: route chroma and ramp to channels by sector, add the offset,
// scale to 8 bits and select by color model. Uses hhr_pkg.
module hhr_mix
   import hhr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ctl_type            ctl_in,
   input  logic [FRAC_BITS:0] chroma,
   input  logic [FRAC_BITS:0] ramp,
   input  logic [FRAC_BITS:0] offset_m,
   output rsp_data_type       rsp_data
);

   logic [FRAC_BITS:0]   part_r;
   logic [FRAC_BITS:0]   part_g;
   logic [FRAC_BITS:0]   part_b;
   logic [FRAC_BITS+1:0] sum_r_in;
   logic [FRAC_BITS+1:0] sum_g_in;
   logic [FRAC_BITS+1:0] sum_b_in;
   logic [FRAC_BITS+1:0] sum_r_ff;
   logic [FRAC_BITS+1:0] sum_g_ff;
   logic [FRAC_BITS+1:0] sum_b_ff;
   ctl_type              ctl5_ff;
   rsp_data_type         rsp_in;
   rsp_data_type         rsp_ff;

   // Scale a fixed-point level by 255 and truncate, saturating at 255
   function automatic logic [7:0] to_byte(input logic [FRAC_BITS+1:0] q);
      logic [FRAC_BITS+9:0] scaled;
      logic [9:0]           level;
      scaled = {q, 8'd0} - {8'd0, q};
      level  = scaled[FRAC_BITS+9:FRAC_BITS];
      return (level > {2'b00, CHAN_MAX}) ? CHAN_MAX : level[7:0];
   endfunction

   // Route chroma and ramp to the channels of this sector
   always_comb begin
      case (ctl_in.sector)
         3'd0: begin
            part_r = chroma; part_g = ramp;   part_b = '0;
         end
         3'd1: begin
            part_r = ramp;   part_g = chroma; part_b = '0;
         end
         3'd2: begin
            part_r = '0;     part_g = chroma; part_b = ramp;
         end
         3'd3: begin
            part_r = '0;     part_g = ramp;   part_b = chroma;
         end
         3'd4: begin
            part_r = ramp;   part_g = '0;     part_b = chroma;
         end
         default: begin
            part_r = chroma; part_g = '0;     part_b = ramp;
         end
      endcase
      sum_r_in = {1'b0, part_r} + {1'b0, offset_m};
      sum_g_in = {1'b0, part_g} + {1'b0, offset_m};
      sum_b_in = {1'b0, part_b} + {1'b0, offset_m};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl5_ff  <= ctl_in;
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
      end
   end

   // Pick the result by color model; an unused code gives black
   always_comb begin
      rsp_in.valid     = ctl5_ff.valid;
      rsp_in.alpha_out = ctl5_ff.alpha;
      case (ctl5_ff.func)
         FUNC_RGB: begin
            rsp_in.red   = ctl5_ff.red_pass;
            rsp_in.green = ctl5_ff.green_pass;
            rsp_in.blue  = ctl5_ff.blue_pass;
         end
         FUNC_HSV, FUNC_HSL: begin
            rsp_in.red   = to_byte(sum_r_ff);
            rsp_in.green = to_byte(sum_g_ff);
            rsp_in.blue  = to_byte(sum_b_ff);
         end
         default: begin
            rsp_in.red   = '0;
            rsp_in.green = '0;
            rsp_in.blue  = '0;
         end
      endcase
   end

   // Output register; hold the result until the response is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/hsv_hsl_to_rgb_unit.sv =====
// HSV/HSL/RGB to 8-bit RGBA converter, six register stages deep.
// A request is captured at the accepting edge and passes the front, chroma,
// ramp, quotient, sum and output registers. Throughput: one request per cycle
// unless responses stall; the chroma, ramp and reciprocal multipliers are fully pipelined.
// Reset (synchronous) empties the pipeline; no other state is kept.
module hsv_hsl_to_rgb_unit
   import hhr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   hhr_req_if.sink    req_bus,
   hhr_rsp_if.source  rsp_bus
);

   logic               advance;
   req_data_type       req_data;
   ctl_type            front_ctl;
   logic [FRAC_BITS:0] sat_q;
   logic [FRAC_BITS:0] lum_q;
   logic [FRAC_BITS:0] mul_q;
   ctl_type            chroma_ctl;
   logic [FRAC_BITS:0] chroma;
   logic [FRAC_BITS:0] ramp;
   logic [FRAC_BITS:0] offset_m;
   rsp_data_type       rsp_data;

   // Advance all stages unless a finished response is waiting
   assign advance       = !rsp_data.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Pack the request payload
   assign req_data.func         = req_bus.func;
   assign req_data.first_value  = req_bus.first_value;
   assign req_data.second_value = req_bus.second_value;
   assign req_data.third_value  = req_bus.third_value;
   assign req_data.alpha_in     = req_bus.alpha_in;

   hhr_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_bus.valid),
      .req_data (req_data),
      .ctl_out  (front_ctl),
      .sat_q    (sat_q),
      .lum_q    (lum_q),
      .mul_q    (mul_q)
   );

   hhr_chroma #(
      .FRAC_BITS (FRAC_BITS)
   ) u_chroma (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_in   (front_ctl),
      .sat_q    (sat_q),
      .lum_q    (lum_q),
      .mul_q    (mul_q),
      .ctl_out  (chroma_ctl),
      .chroma   (chroma),
      .ramp     (ramp),
      .offset_m (offset_m)
   );

   hhr_mix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mix (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_in   (chroma_ctl),
      .chroma   (chroma),
      .ramp     (ramp),
      .offset_m (offset_m),
      .rsp_data (rsp_data)
   );

   // Drive the response channel from the output register
   assign rsp_bus.valid     = rsp_data.valid;
   assign rsp_bus.red       = rsp_data.red;
   assign rsp_bus.green     = rsp_data.green;
   assign rsp_bus.blue      = rsp_data.blue;
   assign rsp_bus.alpha_out = rsp_data.alpha_out;

endmodule

// ===== dv/tb_hsv_hsl_to_rgb_unit.sv =====
`timescale 1ns / 100ps
// Testbench for hsv_hsl_to_rgb_unit: random and directed color requests are
// checked against a fixed-point color predictor held in a scoreboard class.
// Depends on hhr_pkg, hhr_req_if, hhr_rsp_if and the converter RTL.

module tb_hsv_hsl_to_rgb_unit
   import hhr_pkg::*;
();

   localparam int FRAC = FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_out;
   } pixel_type;

   // Expected pixels in request order, with the color math that fills them
   class color_scoreboard_type;
      pixel_type   expected_q[$];
      int unsigned mismatches = 0;

      function automatic longint clip(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Scale a fixed-point channel to 8 bits, saturating at full scale
      function automatic logic [7:0] scale_byte(longint unsigned q);
         longint unsigned v;
         v = (q * 255) >> FRAC;
         return (v > 255) ? 8'd255 : v[7:0];
      endfunction

      function automatic pixel_type convert_pixel(func_type f,
                                                  logic signed [10:0] v1,
                                                  logic signed [10:0] v2,
                                                  logic signed [10:0] v3,
                                                  logic signed [10:0] va);
         pixel_type p;
         longint unsigned one, hue, sat, lvl, chroma, offs, ramp, t, d;
         longint unsigned twol, dev, pr, pg, pb;
         one = longint'(1) << FRAC;
         p = '0;
         p.alpha_out = 8'(clip(va, 0, 255));
         case (f)
            FUNC_RGB: begin
               p.red   = 8'(clip(v1, 0, 255));
               p.green = 8'(clip(v2, 0, 255));
               p.blue  = 8'(clip(v3, 0, 255));
            end
            FUNC_HSV, FUNC_HSL: begin
               hue = clip(v1, 0, 359);
               sat = (clip(v2, 0, 100) << FRAC) / 100;
               lvl = (clip(v3, 0, 100) << FRAC) / 100;
               if (f == FUNC_HSV) begin
                  chroma = (sat * lvl) >> FRAC;
                  offs   = lvl - chroma;
               end else begin
                  twol   = 2 * lvl;
                  dev    = (twol >= one) ? twol - one : one - twol;
                  chroma = ((one - dev) * sat) >> FRAC;
                  offs   = lvl - (chroma >> 1);
               end
               // Ramp term from the position inside the 120-degree period
               t    = hue % 120;
               d    = (t >= 60) ? t - 60 : 60 - t;
               ramp = (chroma * (60 - d)) / 60;
               case (hue / 60)
                  0: begin pr = chroma; pg = ramp;   pb = 0;      end
                  1: begin pr = ramp;   pg = chroma; pb = 0;      end
                  2: begin pr = 0;      pg = chroma; pb = ramp;   end
                  3: begin pr = 0;      pg = ramp;   pb = chroma; end
                  4: begin pr = ramp;   pg = 0;      pb = chroma; end
                  default: begin pr = chroma; pg = 0; pb = ramp;  end
               endcase
               p.red   = scale_byte(pr + offs);
               p.green = scale_byte(pg + offs);
               p.blue  = scale_byte(pb + offs);
            end
            default: ;
         endcase
         return p;
      endfunction

      function void note_request(logic [1:0] f, logic signed [10:0] v1,
                                 logic signed [10:0] v2, logic signed [10:0] v3,
                                 logic signed [10:0] va);
         expected_q.push_back(convert_pixel(func_type'(f), v1, v2, v3, va));
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type exp;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            mismatches++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.red !== exp.red) begin
            $error("red: expected %0d, actual %0d", exp.red, got.red);
            mismatches++;
         end
         if (got.green !== exp.green) begin
            $error("green: expected %0d, actual %0d", exp.green, got.green);
            mismatches++;
         end
         if (got.blue !== exp.blue) begin
            $error("blue: expected %0d, actual %0d", exp.blue, got.blue);
            mismatches++;
         end
         if (got.alpha_out !== exp.alpha_out) begin
            $error("alpha_out: expected %0d, actual %0d", exp.alpha_out, got.alpha_out);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;

   color_scoreboard_type sb = new();

   hhr_req_if req_if ();
   hhr_rsp_if rsp_if ();

   hsv_hsl_to_rgb_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the response side at the current rate
   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Record accepted requests and check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_request(req_if.func, req_if.first_value, req_if.second_value,
                            req_if.third_value, req_if.alpha_in);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_pixel({rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.alpha_out});
         end
      end
   end

   // Present one request, idling first at the current rate, and hold it until taken
   task automatic send_pixel(func_type f, logic signed [10:0] v1,
                             logic signed [10:0] v2, logic signed [10:0] v3,
                             logic signed [10:0] va);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.func         = f;
      req_if.first_value  = v1;
      req_if.second_value = v2;
      req_if.third_value  = v3;
      req_if.alpha_in     = va;
      do begin
         @(posedge clock);
         taken = req_if.ready;
         @(negedge clock);
      end while (!taken);
   endtask

   // Mostly in range, sometimes any 11-bit value to exercise the clamps
   function automatic logic signed [10:0] pick_field(int hi);
      if ($urandom_range(4) == 0) return 11'($urandom);
      return 11'($urandom_range(hi, 0));
   endfunction

   task automatic send_random_pixel();
      func_type           f;
      logic signed [10:0] hue;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 10)      f = FUNC_RGB;
      else if (pick < 50) f = FUNC_HSV;
      else if (pick < 95) f = FUNC_HSL;
      else                f = FUNC_NONE;
      if (f == FUNC_RGB) begin
         send_pixel(f, pick_field(255), pick_field(255), pick_field(255), pick_field(255));
      end else begin
         // Favor hues next to the sector boundaries now and then
         if ($urandom_range(7) == 0) hue = 11'($urandom_range(6) * 60 + $urandom_range(2) - 1);
         else                        hue = pick_field(359);
         send_pixel(f, hue, pick_field(100), pick_field(100), pick_field(255));
      end
   endtask

   // Hold off the sender until every response has come back
   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.func         = FUNC_RGB;
      req_if.first_value  = '0;
      req_if.second_value = '0;
      req_if.third_value  = '0;
      req_if.alpha_in     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: passthrough extremes and clamps
      send_pixel(FUNC_RGB, 11'sd0, 11'sd0, 11'sd0, 11'sd0);
      send_pixel(FUNC_RGB, 11'sd255, 11'sd255, 11'sd255, 11'sd255);
      send_pixel(FUNC_RGB, -11'sd1024, 11'sd1023, -11'sd1, 11'sd1023);
      send_pixel(FUNC_RGB, 11'sd256, -11'sd1024, 11'sd128, -11'sd1);
      // Directed: HSV at every sector start and the hue extremes
      send_pixel(FUNC_HSV, 11'sd0, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd60, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd120, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd180, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd240, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd300, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, 11'sd359, 11'sd100, 11'sd100, 11'sd255);
      send_pixel(FUNC_HSV, -11'sd1024, 11'sd1023, 11'sd1023, 11'sd1023);
      send_pixel(FUNC_HSV, 11'sd1023, -11'sd5, 11'sd50, 11'sd17);
      send_pixel(FUNC_HSV, 11'sd30, 11'sd50, 11'sd75, 11'sd128);
      // Directed: HSL around the lightness midpoint and its ends
      send_pixel(FUNC_HSL, 11'sd0, 11'sd100, 11'sd50, 11'sd255);
      send_pixel(FUNC_HSL, 11'sd90, 11'sd100, 11'sd50, 11'sd200);
      send_pixel(FUNC_HSL, 11'sd210, 11'sd80, 11'sd30, 11'sd64);
      send_pixel(FUNC_HSL, 11'sd330, 11'sd100, 11'sd100, 11'sd1);
      send_pixel(FUNC_HSL, 11'sd150, 11'sd100, 11'sd0, 11'sd254);
      send_pixel(FUNC_HSL, 11'sd270, 11'sd1023, -11'sd1, 11'sd300);
      send_pixel(FUNC_HSL, 11'sd45, 11'sd37, 11'sd63, 11'sd99);
      // Directed: unused selector keeps only the opacity
      send_pixel(FUNC_NONE, 11'sd123, 11'sd45, 11'sd67, 11'sd200);
      send_pixel(FUNC_NONE, -11'sd1, -11'sd1, -11'sd1, -11'sd1);
      req_if.valid = 1'b0;
      drain();

      // Random, sender lightly idle and receiver often stalled
      send_idle_pct = 16;
      recv_idle_pct = 48;
      repeat (600) send_random_pixel();
      req_if.valid = 1'b0;
      drain();

      // Random, roles swapped
      send_idle_pct = 48;
      recv_idle_pct = 16;
      repeat (600) send_random_pixel();
      req_if.valid = 1'b0;
      drain();

      // Random, full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (550) send_random_pixel();
      req_if.valid = 1'b0;
      drain();
      repeat (12) @(negedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_hsv_hsl_to_rgb_unit: PASS");
      end else begin
         $display("tb_hsv_hsl_to_rgb_unit: FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("tb_hsv_hsl_to_rgb_unit: FAIL");
      $finish;
   end

endmodule
